// ===== design/assert_macros.svh =====
// Assertion macros shared by the slew command encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge of aclk, outside of reset.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checks an implication on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/asce_pkg.sv =====
// Package with types, constants and helpers of the slew command encoder.
`default_nettype none
package asce_pkg;

    localparam int VEL_W    = 32;
    localparam int THR_W    = 31;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W    = 4;
    localparam int QUEUE_DEPTH = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ALTITUDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUIDE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW     = 3'd5;

    localparam logic [THR_W-1:0] GUIDE_RESET  = 31'd132;
    localparam logic [THR_W-1:0] CENTER_RESET = 31'd2294;
    localparam logic [THR_W-1:0] MEDIUM_RESET = 31'd131072;
    localparam logic [THR_W-1:0] SLEW_RESET   = 31'd327680;

    // ASCII codes of the command frames.
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_Q     = 8'h51;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
    localparam logic [BYTE_W-1:0] CH_N_LO  = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_S_LO  = 8'h73;
    localparam logic [BYTE_W-1:0] CH_W_LO  = 8'h77;
    localparam logic [BYTE_W-1:0] CH_E_LO  = 8'h65;

    // Byte positions inside a four-byte frame.
    localparam logic [1:0] POS_OPEN  = 2'd0;
    localparam logic [1:0] POS_CMD   = 2'd1;
    localparam logic [1:0] POS_ARG   = 2'd2;
    localparam logic [1:0] POS_CLOSE = 2'd3;

    // Frame slots of one transaction; the leading halt pair only on a sign flip.
    localparam logic [1:0] FR_FLIP_POS = 2'd0;
    localparam logic [1:0] FR_FLIP_NEG = 2'd1;
    localparam logic [1:0] FR_MAIN_A   = 2'd2;
    localparam logic [1:0] FR_MAIN_B   = 2'd3;

    localparam logic [CNT_W-1:0] CNT_FIRST_FULL  = 4'd0;
    localparam logic [CNT_W-1:0] CNT_FIRST_SHORT = 4'd8;
    localparam logic [CNT_W-1:0] CNT_LAST        = 4'd15;

    typedef struct packed {
        logic               flip;
        logic               halt;
        logic [BYTE_W-1:0]  rate;
        logic [BYTE_W-1:0]  move;
        logic [BYTE_W-1:0]  pos;
        logic [BYTE_W-1:0]  neg;
        logic [VEL_W-1:0]   rep;
    } cmd_t;

    // Negation that maps the most negative value to the most positive one.
    function automatic logic [VEL_W-1:0] sat_negate(input logic [VEL_W-1:0] v);
        logic [VEL_W-1:0] r;
        if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
            r = {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            r = (~v) + {{(VEL_W-1){1'b0}}, 1'b1};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/asce_front.sv =====
// Front end: takes a velocity, classifies it and builds a command descriptor.
`default_nettype none
module asce_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_accept,
    input  wire logic [asce_pkg::VEL_W-1:0]   in_velocity,
    input  wire logic                         alt_select,
    input  wire logic                         reverse_direction,
    input  wire logic [asce_pkg::THR_W-1:0]   guide_threshold,
    input  wire logic [asce_pkg::THR_W-1:0]   center_threshold,
    input  wire logic [asce_pkg::THR_W-1:0]   medium_threshold,
    input  wire logic [asce_pkg::THR_W-1:0]   slew_threshold,
    output asce_pkg::cmd_t                    cmd
);

    logic [asce_pkg::VEL_W-1:0]  stored_reg;
    logic [asce_pkg::VEL_W-1:0]  stored_next;
    logic [asce_pkg::VEL_W-1:0]  mag;
    logic [asce_pkg::VEL_W-1:0]  vrev;
    logic [asce_pkg::VEL_W-1:0]  veff;
    logic [asce_pkg::BYTE_W-1:0] rate;
    logic                        below;
    logic                        stored_neg;
    logic                        stored_pos;
    logic                        veff_neg;
    logic                        veff_pos;

    always_comb begin
        // Magnitude of the raw input; the most negative value gives 2^31.
        mag  = in_velocity[asce_pkg::VEL_W-1] ?
               ((~in_velocity) + {{(asce_pkg::VEL_W-1){1'b0}}, 1'b1}) : in_velocity;
        vrev = reverse_direction ? asce_pkg::sat_negate(in_velocity) : in_velocity;

        below = 1'b0;
        if (mag >= {1'b0, slew_threshold}) begin
            rate = asce_pkg::CH_S;
        end else if (mag >= {1'b0, medium_threshold}) begin
            rate = asce_pkg::CH_M;
        end else if (mag >= {1'b0, center_threshold}) begin
            rate = asce_pkg::CH_C;
        end else if (mag >= {1'b0, guide_threshold}) begin
            rate = asce_pkg::CH_G;
        end else begin
            rate  = '0;
            below = 1'b1;
        end

        veff       = below ? '0 : vrev;
        stored_neg = stored_reg[asce_pkg::VEL_W-1];
        stored_pos = !stored_reg[asce_pkg::VEL_W-1] && (stored_reg != '0);
        veff_neg   = veff[asce_pkg::VEL_W-1];
        veff_pos   = !veff[asce_pkg::VEL_W-1] && (veff != '0);

        cmd.flip = (stored_neg && veff_pos) || (stored_pos && veff_neg);
        cmd.halt = (veff == '0);
        cmd.rate = rate;
        cmd.pos  = alt_select ? asce_pkg::CH_N_LO : asce_pkg::CH_W_LO;
        cmd.neg  = alt_select ? asce_pkg::CH_S_LO : asce_pkg::CH_E_LO;
        cmd.move = veff_pos ? cmd.pos : cmd.neg;
        cmd.rep  = reverse_direction ? asce_pkg::sat_negate(veff) : veff;

        stored_next = in_accept ? veff : stored_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg <= '0;
        end else begin
            stored_reg <= stored_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/asce_queue.sv =====
// Short descriptor queue between the front end and the byte sequencer.
`default_nettype none
module asce_queue #(
    parameter int DEPTH = asce_pkg::QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  asce_pkg::cmd_t push_data,
    output logic           full,
    input  wire logic      pop,
    output logic           empty,
    output asce_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    asce_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        full    = (count_reg == CNT_FULL);
        empty   = (count_reg == '0);
        head    = entry_reg[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && !empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/asce_back.sv =====
// Back end: walks a descriptor byte by byte into the registered output stage.
`default_nettype none
module asce_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_empty,
    input  asce_pkg::cmd_t                     q_head,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [asce_pkg::BYTE_W-1:0]        out_byte,
    output logic [asce_pkg::VEL_W-1:0]         out_rep,
    output logic                               out_frame_end,
    output logic                               out_last
);

    logic                          active_reg;
    logic                          active_next;
    logic [asce_pkg::CNT_W-1:0]    cnt_reg;
    logic [asce_pkg::CNT_W-1:0]    cnt_next;
    logic [asce_pkg::CNT_W-1:0]    cur_cnt;
    logic                          valid_reg;
    logic                          valid_next;
    logic [asce_pkg::BYTE_W-1:0]   byte_reg;
    logic [asce_pkg::VEL_W-1:0]    rep_reg;
    logic                          fend_reg;
    logic                          last_reg;
    logic [asce_pkg::BYTE_W-1:0]   cmd_byte;
    logic [asce_pkg::BYTE_W-1:0]   arg_byte;
    logic [asce_pkg::BYTE_W-1:0]   cur_byte;
    logic                          load;
    logic                          emit;

    always_comb begin
        // A transaction without a sign flip skips the leading halt pair.
        cur_cnt = active_reg ? cnt_reg :
                  (q_head.flip ? asce_pkg::CNT_FIRST_FULL : asce_pkg::CNT_FIRST_SHORT);

        case (cur_cnt[3:2])
            asce_pkg::FR_FLIP_POS: begin
                cmd_byte = asce_pkg::CH_Q;
                arg_byte = q_head.pos;
            end
            asce_pkg::FR_FLIP_NEG: begin
                cmd_byte = asce_pkg::CH_Q;
                arg_byte = q_head.neg;
            end
            asce_pkg::FR_MAIN_A: begin
                cmd_byte = q_head.halt ? asce_pkg::CH_Q : asce_pkg::CH_R;
                arg_byte = q_head.halt ? q_head.pos : q_head.rate;
            end
            asce_pkg::FR_MAIN_B: begin
                cmd_byte = q_head.halt ? asce_pkg::CH_Q : asce_pkg::CH_M;
                arg_byte = q_head.halt ? q_head.neg : q_head.move;
            end
            default: begin
                cmd_byte = asce_pkg::CH_Q;
                arg_byte = q_head.pos;
            end
        endcase

        case (cur_cnt[1:0])
            asce_pkg::POS_OPEN:  cur_byte = asce_pkg::CH_COLON;
            asce_pkg::POS_CMD:   cur_byte = cmd_byte;
            asce_pkg::POS_ARG:   cur_byte = arg_byte;
            asce_pkg::POS_CLOSE: cur_byte = asce_pkg::CH_HASH;
            default:             cur_byte = asce_pkg::CH_HASH;
        endcase

        load  = !valid_reg || out_ready;
        emit  = load && !q_empty;
        q_pop = emit && (cur_cnt == asce_pkg::CNT_LAST);

        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (emit) begin
            active_next = (cur_cnt != asce_pkg::CNT_LAST);
            cnt_next    = cur_cnt + 1'b1;
        end
        valid_next = load ? emit : valid_reg;

        out_valid     = valid_reg;
        out_byte      = byte_reg;
        out_rep       = rep_reg;
        out_frame_end = fend_reg;
        out_last      = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= cur_byte;
            rep_reg  <= q_head.rep;
            fend_reg <= (cur_cnt[1:0] == asce_pkg::POS_CLOSE);
            last_reg <= (cur_cnt == asce_pkg::CNT_LAST);
        end
    end

endmodule
`default_nettype wire

// ===== design/axis_slew_command_encoder.sv =====
// Top level of the slew command encoder: configuration, front end, queue, back end.
// An accepted velocity is written into the queue; if the queue was empty and the
// output is free, the back end then registers its first byte into the output stage.
// A velocity gives 8 bytes, 16 on a sign flip. The back end emits one byte per cycle
// unless the output stalls; the front end takes one per cycle if the queue has room.
// Reset (aresetn low, synchronous) clears the stored velocity, the queue and the output
`default_nettype none
`include "assert_macros.svh"
module axis_slew_command_encoder #(
    parameter int QUEUE_DEPTH = asce_pkg::QUEUE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // velocity [31:0]
    input  wire logic [asce_pkg::VEL_W-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_byte [7:0], reported_velocity [39:8]
    output logic [asce_pkg::BYTE_W+asce_pkg::VEL_W-1:0] m_tdata,
    // frame_end [0]
    output logic [0:0]                             m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [asce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [asce_pkg::THR_W-1:0]        cfg_data
);

    // Reset also loads the threshold and axis registers with their defaults.
    logic                        altitude_reg;
    logic                        altitude_next;
    logic                        reverse_reg;
    logic                        reverse_next;
    logic [asce_pkg::THR_W-1:0]  guide_reg;
    logic [asce_pkg::THR_W-1:0]  guide_next;
    logic [asce_pkg::THR_W-1:0]  center_reg;
    logic [asce_pkg::THR_W-1:0]  center_next;
    logic [asce_pkg::THR_W-1:0]  medium_reg;
    logic [asce_pkg::THR_W-1:0]  medium_next;
    logic [asce_pkg::THR_W-1:0]  slew_reg;
    logic [asce_pkg::THR_W-1:0]  slew_next;

    asce_pkg::cmd_t              front_cmd;
    asce_pkg::cmd_t              q_head;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_pop;
    logic                        in_accept;
    logic [asce_pkg::BYTE_W-1:0] out_byte;
    logic [asce_pkg::VEL_W-1:0]  out_rep;
    logic                        out_frame_end;

    always_comb begin
        altitude_next = altitude_reg;
        reverse_next  = reverse_reg;
        guide_next    = guide_reg;
        center_next   = center_reg;
        medium_next   = medium_reg;
        slew_next     = slew_reg;
        if (cfg_we) begin
            case (cfg_index)
                asce_pkg::REG_ALTITUDE: altitude_next = cfg_data[0];
                asce_pkg::REG_REVERSE:  reverse_next  = cfg_data[0];
                asce_pkg::REG_GUIDE:    guide_next    = cfg_data;
                asce_pkg::REG_CENTER:   center_next   = cfg_data;
                asce_pkg::REG_MEDIUM:   medium_next   = cfg_data;
                asce_pkg::REG_SLEW:     slew_next     = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            altitude_reg <= 1'b0;
            reverse_reg  <= 1'b0;
            guide_reg    <= asce_pkg::GUIDE_RESET;
            center_reg   <= asce_pkg::CENTER_RESET;
            medium_reg   <= asce_pkg::MEDIUM_RESET;
            slew_reg     <= asce_pkg::SLEW_RESET;
        end else begin
            altitude_reg <= altitude_next;
            reverse_reg  <= reverse_next;
            guide_reg    <= guide_next;
            center_reg   <= center_next;
            medium_reg   <= medium_next;
            slew_reg     <= slew_next;
        end
    end

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && !q_full;

    asce_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_accept         (in_accept),
        .in_velocity       (s_tdata),
        .alt_select        (altitude_reg),
        .reverse_direction (reverse_reg),
        .guide_threshold   (guide_reg),
        .center_threshold  (center_reg),
        .medium_threshold  (medium_reg),
        .slew_threshold    (slew_reg),
        .cmd               (front_cmd)
    );

    asce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    asce_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (out_byte),
        .out_rep       (out_rep),
        .out_frame_end (out_frame_end),
        .out_last      (m_tlast)
    );

    assign m_tdata = {out_rep, out_byte};
    assign m_tuser = out_frame_end;

    // The final byte of a transaction always closes a frame.
    `ASSERT_CLKD(a_last_closes_frame, m_tvalid && m_tlast |-> m_tuser[0],
                 "last byte not a frame end")
    // Frame ends carry the closing character.
    `ASSERT_CLKD(a_frame_end_char, m_tvalid && m_tuser[0] |-> out_byte == asce_pkg::CH_HASH,
                 "frame end without closing character")
    // Within one transaction the read-back velocity does not change.
    `ASSERT_CLKD(a_rep_steady,
                 m_tvalid && m_tready && !m_tlast |=> !m_tvalid || out_rep == $past(out_rep),
                 "reported velocity changed inside a transaction")
    // The sequencer only pops a descriptor that is there.
    `ASSERT_ALWAYS(a_pop_nonempty, q_pop |-> !q_empty, "queue popped while empty")

endmodule
`default_nettype wire

// ===== bench/tb_axis_slew_command_encoder.sv =====
// Self-checking testbench for the slew command encoder: directed and random velocity streams.
`timescale 1ns / 100ps
module tb_axis_slew_command_encoder;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 46;
    localparam int HOLD_CYCLES = 300;

    localparam logic [asce_pkg::VEL_W-1:0] VEL_MOST_NEG = 32'h8000_0000;
    localparam logic [asce_pkg::VEL_W-1:0] VEL_MOST_POS = 32'h7FFF_FFFF;
    localparam logic [asce_pkg::THR_W-1:0] THR_MAX = 31'h7FFF_FFFF;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [asce_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [asce_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [asce_pkg::BYTE_W-1:0] out_byte;
        logic                        frame_end;
        logic                        last;
        logic [asce_pkg::VEL_W-1:0]  reported;
    } frame_byte_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [asce_pkg::VEL_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [asce_pkg::BYTE_W+asce_pkg::VEL_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [asce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [asce_pkg::THR_W-1:0] cfg_data = '0;

    // Mirror of the block's registers and stored velocity.
    logic                       axis_alt;
    logic                       axis_rev;
    logic [asce_pkg::THR_W-1:0] thr_guide;
    logic [asce_pkg::THR_W-1:0] thr_center;
    logic [asce_pkg::THR_W-1:0] thr_medium;
    logic [asce_pkg::THR_W-1:0] thr_slew;
    logic signed [asce_pkg::VEL_W-1:0] held_velocity;

    frame_byte_t expected_bytes[$];
    frame_byte_t exp_byte;
    int mismatches = 0;
    int cycle_count = 0;
    bit idle_on = 1'b1;
    int hold_request = 0;

    axis_slew_command_encoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [asce_pkg::VEL_W-1:0] negate_clamped(
            input logic [asce_pkg::VEL_W-1:0] x);
        if (x == VEL_MOST_NEG) begin
            return VEL_MOST_POS;
        end
        return -x;
    endfunction

    // Keeps the low bits of a random word that fit a threshold register.
    function automatic logic [asce_pkg::THR_W-1:0] thr_from(input logic [31:0] x);
        return x[asce_pkg::THR_W-1:0];
    endfunction

    function automatic void push_frame(input logic [asce_pkg::BYTE_W-1:0] cmd,
                                       input logic [asce_pkg::BYTE_W-1:0] arg,
                                       input logic [asce_pkg::VEL_W-1:0] rep,
                                       input logic final_frame);
        frame_byte_t b;
        b.reported = rep;
        b.frame_end = 1'b0;
        b.last = 1'b0;
        b.out_byte = asce_pkg::CH_COLON;
        expected_bytes.push_back(b);
        b.out_byte = cmd;
        expected_bytes.push_back(b);
        b.out_byte = arg;
        expected_bytes.push_back(b);
        b.out_byte = asce_pkg::CH_HASH;
        b.frame_end = 1'b1;
        b.last = final_frame;
        expected_bytes.push_back(b);
    endfunction

    // Works out the command bytes that one accepted velocity produces.
    function automatic void encode_velocity(input logic [asce_pkg::VEL_W-1:0] vin);
        logic signed [asce_pkg::VEL_W-1:0] v;
        logic [asce_pkg::VEL_W-1:0] mag;
        logic [asce_pkg::BYTE_W-1:0] rate;
        logic [asce_pkg::BYTE_W-1:0] pos_dir;
        logic [asce_pkg::BYTE_W-1:0] neg_dir;
        logic [asce_pkg::VEL_W-1:0] rep;
        logic sign_flip;
        v = vin;
        // The magnitude comes from the raw input; the most negative value gives 2^31.
        mag = vin[asce_pkg::VEL_W-1] ? (~vin + 1'b1) : vin;
        if (axis_rev) begin
            v = negate_clamped(v);
        end
        rate = '0;
        if (mag >= {1'b0, thr_slew}) begin
            rate = asce_pkg::CH_S;
        end else if (mag >= {1'b0, thr_medium}) begin
            rate = asce_pkg::CH_M;
        end else if (mag >= {1'b0, thr_center}) begin
            rate = asce_pkg::CH_C;
        end else if (mag >= {1'b0, thr_guide}) begin
            rate = asce_pkg::CH_G;
        end else begin
            v = '0;
        end
        pos_dir = axis_alt ? asce_pkg::CH_N_LO : asce_pkg::CH_W_LO;
        neg_dir = axis_alt ? asce_pkg::CH_S_LO : asce_pkg::CH_E_LO;
        sign_flip = (held_velocity < 0 && v > 0) || (held_velocity > 0 && v < 0);
        held_velocity = v;
        rep = axis_rev ? negate_clamped(held_velocity) : held_velocity;
        if (sign_flip) begin
            push_frame(asce_pkg::CH_Q, pos_dir, rep, 1'b0);
            push_frame(asce_pkg::CH_Q, neg_dir, rep, 1'b0);
        end
        if (v != 0) begin
            push_frame(asce_pkg::CH_R, rate, rep, 1'b0);
            push_frame(asce_pkg::CH_M, (v > 0) ? pos_dir : neg_dir, rep, 1'b1);
        end else begin
            push_frame(asce_pkg::CH_Q, pos_dir, rep, 1'b0);
            push_frame(asce_pkg::CH_Q, neg_dir, rep, 1'b1);
        end
    endfunction

    task automatic send_velocity(input logic [asce_pkg::VEL_W-1:0] vel);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= vel;
        do @(posedge aclk); while (!s_tready);
        encode_velocity(vel);
    endtask

    task automatic write_register(input logic [asce_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [asce_pkg::THR_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            asce_pkg::REG_ALTITUDE: axis_alt = data[0];
            asce_pkg::REG_REVERSE:  axis_rev = data[0];
            asce_pkg::REG_GUIDE:    thr_guide = data;
            asce_pkg::REG_CENTER:   thr_center = data;
            asce_pkg::REG_MEDIUM:   thr_medium = data;
            asce_pkg::REG_SLEW:     thr_slew = data;
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input logic [asce_pkg::THR_W-1:0] g,
                                  input logic [asce_pkg::THR_W-1:0] c,
                                  input logic [asce_pkg::THR_W-1:0] m,
                                  input logic [asce_pkg::THR_W-1:0] s);
        write_register(asce_pkg::REG_GUIDE, g);
        write_register(asce_pkg::REG_CENTER, c);
        write_register(asce_pkg::REG_MEDIUM, m);
        write_register(asce_pkg::REG_SLEW, s);
    endtask

    // Drains every outstanding byte so that the registers may be changed.
    task automatic drain_stream();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stalls per byte, plus one long hold on request.
    initial begin
        int stall;
        int hold;
        @(posedge aresetn);
        forever begin
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                stall = idle_on ? $urandom_range(0, 15) : 0;
                @(negedge aclk);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result byte %h", m_tdata[asce_pkg::BYTE_W-1:0]);
                mismatches++;
            end else begin
                exp_byte = expected_bytes.pop_front();
                if (m_tdata[asce_pkg::BYTE_W-1:0] !== exp_byte.out_byte) begin
                    $error("out_byte: expected %h, actual %h",
                           exp_byte.out_byte, m_tdata[asce_pkg::BYTE_W-1:0]);
                    mismatches++;
                end
                if (m_tuser[0] !== exp_byte.frame_end) begin
                    $error("frame_end: expected %b, actual %b", exp_byte.frame_end, m_tuser[0]);
                    mismatches++;
                end
                if (m_tlast !== exp_byte.last) begin
                    $error("last: expected %b, actual %b", exp_byte.last, m_tlast);
                    mismatches++;
                end
                if (m_tdata[asce_pkg::BYTE_W+asce_pkg::VEL_W-1:asce_pkg::BYTE_W]
                        !== exp_byte.reported) begin
                    $error("reported_velocity: expected %h, actual %h", exp_byte.reported,
                           m_tdata[asce_pkg::BYTE_W+asce_pkg::VEL_W-1:asce_pkg::BYTE_W]);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [asce_pkg::VEL_W-1:0] pick_velocity();
        logic [asce_pkg::VEL_W-1:0] mag;
        logic [asce_pkg::THR_W-1:0] t;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: t = thr_guide;
                    1: t = thr_center;
                    2: t = thr_medium;
                    default: t = thr_slew;
                endcase
                mag = {1'b0, t} + $urandom_range(0, 4) - 2;
            end
            2: mag = $urandom_range(0, {1'b0, thr_guide});
            3: begin
                case ($urandom_range(0, 5))
                    0: return VEL_MOST_NEG;
                    1: return VEL_MOST_POS;
                    2: return -VEL_MOST_POS;
                    3: return '0;
                    4: return 32'd1;
                    default: return -32'sd1;
                endcase
            end
            default: mag = $urandom_range(0, {1'b0, thr_slew} << 1);
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic test_default_rates();
        send_velocity(32'd0);
        send_velocity(32'd131);
        send_velocity(32'd132);
        send_velocity(32'd2294);
        send_velocity(32'd131072);
        send_velocity(32'd327680);
        send_velocity(-32'sd327680);
        send_velocity(VEL_MOST_NEG);
        send_velocity(VEL_MOST_POS);
        send_velocity(-32'sd131);
        drain_stream();
    endtask

    task automatic test_axis_and_reverse();
        write_register(asce_pkg::REG_ALTITUDE, 31'd1);
        write_register(asce_pkg::REG_REVERSE, 31'd1);
        send_velocity(32'd500000);
        send_velocity(-32'sd500000);
        // Reversing the most negative input clamps it to the most positive value.
        send_velocity(VEL_MOST_NEG);
        send_velocity(32'd0);
        drain_stream();
        // Only bit 0 of a one-bit register is kept.
        write_register(asce_pkg::REG_ALTITUDE, 31'h7FFF_FFFE);
        write_register(asce_pkg::REG_REVERSE, THR_MAX);
        write_register(REG_SPARE_A, 31'd0);
        write_register(REG_SPARE_B, THR_MAX);
        send_velocity(-32'sd3000);
        send_velocity(32'd3000);
        drain_stream();
    endtask

    task automatic test_threshold_extremes();
        write_register(asce_pkg::REG_REVERSE, 31'd0);
        set_thresholds('0, '0, '0, '0);
        // A zero guide threshold still lets a zero velocity halt.
        send_velocity(32'd0);
        send_velocity(32'd1);
        send_velocity(-32'sd1);
        drain_stream();
        set_thresholds(THR_MAX, THR_MAX, THR_MAX, THR_MAX);
        send_velocity(32'h7FFF_FFFE);
        send_velocity(VEL_MOST_POS);
        send_velocity(-VEL_MOST_POS);
        drain_stream();
        // Out of order: the slew test runs first and wins.
        set_thresholds(31'd300000, 31'd200, 31'd100000, 31'd50);
        send_velocity(32'd49);
        send_velocity(32'd50);
        send_velocity(-32'sd100);
        drain_stream();
        set_thresholds(asce_pkg::GUIDE_RESET, asce_pkg::CENTER_RESET,
                       asce_pkg::MEDIUM_RESET, asce_pkg::SLEW_RESET);
    endtask

    task automatic test_fill_and_stall();
        idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) begin
            send_velocity(pick_velocity());
        end
        drain_stream();
        idle_on = 1'b1;
    endtask

    task automatic test_random_stream();
        logic [asce_pkg::THR_W-1:0] g;
        logic [asce_pkg::THR_W-1:0] c;
        logic [asce_pkg::THR_W-1:0] m;
        logic [asce_pkg::THR_W-1:0] s;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_register(asce_pkg::REG_ALTITUDE, thr_from($urandom));
            write_register(asce_pkg::REG_REVERSE, thr_from($urandom));
            case ((phase == 0) ? 3 : $urandom_range(0, 5))
                0: set_thresholds(asce_pkg::GUIDE_RESET, asce_pkg::CENTER_RESET,
                                  asce_pkg::MEDIUM_RESET, asce_pkg::SLEW_RESET);
                1: begin
                    g = thr_from($urandom_range(0, 4));
                    set_thresholds(g, thr_from(g + $urandom_range(0, 8)),
                                   thr_from(g + 20), thr_from(g + 40));
                end
                2: begin
                    g = $urandom_range(0, 1) ? THR_MAX : thr_from($urandom);
                    c = $urandom_range(0, 1) ? '0 : thr_from($urandom);
                    set_thresholds(g, c, thr_from($urandom), thr_from($urandom));
                end
                default: begin
                    g = thr_from($urandom_range(0, 1000));
                    c = thr_from(g + $urandom_range(0, 10000));
                    m = thr_from(c + $urandom_range(0, 200000));
                    s = thr_from(m + $urandom_range(0, 300000));
                    set_thresholds(g, c, m, s);
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i % 10 == 0) begin
                    idle_on = ($urandom_range(0, 3) != 0);
                end
                send_velocity(pick_velocity());
            end
            drain_stream();
            idle_on = 1'b1;
        end
    endtask

    initial begin
        axis_alt = 1'b0;
        axis_rev = 1'b0;
        thr_guide = asce_pkg::GUIDE_RESET;
        thr_center = asce_pkg::CENTER_RESET;
        thr_medium = asce_pkg::MEDIUM_RESET;
        thr_slew = asce_pkg::SLEW_RESET;
        held_velocity = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_default_rates();
        test_axis_and_reverse();
        test_threshold_extremes();
        test_fill_and_stall();
        test_random_stream();
        drain_stream();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
